// ===== hdl/cks_pkg.sv =====
// Shared types and constants of the card key stooge sorter.
package cks_pkg;

  localparam int KEY_W     = 34;
  localparam int SUIT_W    = 2;
  localparam int DIGITS_W  = 32;
  localparam int PHASE_W   = 2;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SH, exact for x < 2**17
  localparam int              RECIP3_W  = 16;
  localparam logic [15:0]     RECIP3    = 16'd43691;
  localparam int              RECIP3_SH = 17;

  // frame phases: first two thirds, last two thirds, first two thirds, done
  localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PH_UPPER = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_RD_LO,
    S_RD_HI,
    S_CMP,
    S_WB,
    S_PUSH,
    S_LOOP,
    S_SUB,
    S_EM_RD,
    S_EM_LD,
    S_EM_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_IDX
  } rd_sel_t;

  typedef struct packed {
    logic    in_ready;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    swap_lo;
    logic    swap_hi;
    logic    start;
    logic    push;
    logic    pop;
    logic    frame_take;
    logic    sub;
    logic    emit_load;
    logic    emit_next;
    logic    batch_clear;
  } cmd_t;

  typedef struct packed {
    logic in_accept;
    logic in_last;
    logic count_zero;
    logic key_gt;
    logic push_ok;
    logic sp_zero;
    logic top_done;
    logic emit_last;
    logic out_taken;
  } status_t;

endpackage

// ===== hdl/cks_in_if.sv =====
// Input channel: one card word per handshake.
interface cks_in_if;
  logic                        valid;
  logic                        ready;
  logic [cks_pkg::SUIT_W-1:0]   suit;
  logic [cks_pkg::DIGITS_W-1:0] value_digits;
  logic                        last_card;

  modport source (output valid, suit, value_digits, last_card, input ready);
  modport sink   (input valid, suit, value_digits, last_card, output ready);
endinterface

// ===== hdl/cks_out_if.sv =====
// Result channel: one sorted card word per handshake.
interface cks_out_if;
  logic                        valid;
  logic                        ready;
  logic [cks_pkg::SUIT_W-1:0]   out_suit;
  logic [cks_pkg::DIGITS_W-1:0] out_value_digits;
  logic                        end_of_batch;
  logic                        overflow;

  modport source (output valid, out_suit, out_value_digits, end_of_batch, overflow,
                  input ready);
  modport sink   (input valid, out_suit, out_value_digits, end_of_batch, overflow,
                  output ready);
endinterface

// ===== hdl/cks_ctrl.sv =====
// Sequencer for loading, stooge sorting and emitting a batch.
module cks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  cks_pkg::status_t sts,
  output cks_pkg::cmd_t    cmd
);
  import cks_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_LO;
    unique case (state_r)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_accept && sts.in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.count_zero) begin
          cmd.batch_clear = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: begin
        cmd.rd_sel = RD_LO;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_sel = RD_HI;
        cmd.cap_a  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.key_gt) begin
          cmd.swap_lo = 1'b1;
          state_nxt = S_WB;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_WB: begin
        cmd.swap_hi = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = sts.push_ok;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.sp_zero) begin
          state_nxt = S_EM_RD;
        end else if (sts.top_done) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.frame_take = 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        state_nxt = S_RD_LO;
      end
      S_EM_RD: begin
        cmd.rd_sel = RD_IDX;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        cmd.emit_load = 1'b1;
        state_nxt = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (sts.out_taken) begin
          if (sts.emit_last) begin
            cmd.batch_clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/cks_datapath.sv =====
// Card store, range stack, compare-swap and output register.
module cks_datapath #(
  parameter int MAX_CARDS   = 64,
  parameter int MAX_DIGITS  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cks_pkg::cmd_t    cmd,
  output cks_pkg::status_t sts,
  cks_in_if.sink           in_ch,
  cks_out_if.source        out_ch
);
  import cks_pkg::*;

  localparam int AW       = $clog2(MAX_CARDS);
  localparam int CW       = $clog2(MAX_CARDS + 1);
  localparam int LW       = AW + 1;
  localparam int PW       = LW + RECIP3_W;
  localparam int SIW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW      = $clog2(STACK_DEPTH + 1);
  localparam int DIG_BITS = (MAX_DIGITS * 4 >= DIGITS_W) ? DIGITS_W : MAX_DIGITS * 4;
  localparam logic [DIGITS_W:0] DIG_MASK_W = ({{DIGITS_W{1'b0}}, 1'b1} << DIG_BITS) -
                                             {{DIGITS_W{1'b0}}, 1'b1};
  localparam logic [DIGITS_W-1:0] DIG_MASK = DIG_MASK_W[DIGITS_W-1:0];

  typedef struct packed {
    logic [AW-1:0]      lo;
    logic [AW-1:0]      hi;
    logic [PHASE_W-1:0] phase;
  } frame_t;

  logic [KEY_W-1:0]   mem [MAX_CARDS];
  logic [KEY_W-1:0]   rd_data_r;
  logic [KEY_W-1:0]   key_a_r;
  frame_t             stack [STACK_DEPTH];

  logic [CW-1:0]      count_r;
  logic               dropped_r;
  logic [SPW-1:0]     sp_r;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      lo_r, hi_r, flo_r, fhi_r, third_r;
  logic [PHASE_W-1:0] ph_r;

  logic                out_valid_r;
  logic [SUIT_W-1:0]   out_suit_r;
  logic [DIGITS_W-1:0] out_digits_r;
  logic                out_eob_r;
  logic                out_ovf_r;

  logic               accept;
  logic [KEY_W-1:0]   in_key;
  logic               room;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic [KEY_W-1:0]   wd;
  logic [SPW-1:0]     sp_m1;
  logic [SIW-1:0]     top;
  frame_t             top_f;
  logic [LW-1:0]      len;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      third_w;
  logic [CW-1:0]      count_m1;

  assign in_ch.ready = cmd.in_ready;
  assign accept      = in_ch.valid & cmd.in_ready;
  assign in_key      = {in_ch.suit, in_ch.value_digits & DIG_MASK};
  assign room        = (count_r < CW'(MAX_CARDS));
  assign count_m1    = count_r - CW'(1);

  assign sp_m1   = sp_r - SPW'(1);
  assign top     = sp_m1[SIW-1:0];
  assign top_f   = stack[top];
  assign len     = LW'(top_f.hi) - LW'(top_f.lo) + LW'(1);
  assign prod    = PW'(len) * PW'(RECIP3);
  assign third_w = prod >> RECIP3_SH;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LO:   rd_addr = lo_r;
      RD_HI:   rd_addr = hi_r;
      RD_IDX:  rd_addr = idx_r;
      default: rd_addr = lo_r;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = lo_r;
    wd = key_a_r;
    if (accept && room) begin
      we = 1'b1;
      wa = count_r[AW-1:0];
      wd = in_key;
    end else if (cmd.swap_lo) begin
      we = 1'b1;
      wa = lo_r;
      wd = rd_data_r;
    end else if (cmd.swap_hi) begin
      we = 1'b1;
      wa = hi_r;
      wd = key_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[sp_r[SIW-1:0]] <= '{lo: lo_r, hi: hi_r, phase: PH_FIRST};
    end else if (cmd.frame_take) begin
      stack[top].phase <= top_f.phase + PHASE_W'(1);
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      key_a_r <= rd_data_r;
    end
    if (cmd.frame_take) begin
      flo_r   <= top_f.lo;
      fhi_r   <= top_f.hi;
      third_r <= third_w[AW-1:0];
      ph_r    <= top_f.phase;
    end
    if (cmd.start) begin
      lo_r <= '0;
      hi_r <= count_m1[AW-1:0];
    end else if (cmd.sub) begin
      if (ph_r == PH_UPPER) begin
        lo_r <= flo_r + third_r;
        hi_r <= fhi_r;
      end else begin
        lo_r <= flo_r;
        hi_r <= fhi_r - third_r;
      end
    end
    if (cmd.emit_load) begin
      out_suit_r   <= rd_data_r[KEY_W-1:DIGITS_W];
      out_digits_r <= rd_data_r[DIGITS_W-1:0];
      out_eob_r    <= sts.emit_last;
      out_ovf_r    <= dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      sp_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.batch_clear) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
        idx_r     <= '0;
      end else begin
        if (accept) begin
          if (room) begin
            count_r <= count_r + CW'(1);
          end else begin
            dropped_r <= 1'b1;
          end
        end
        if (cmd.emit_next) begin
          idx_r <= idx_r + AW'(1);
        end
      end
      if (cmd.start) begin
        sp_r <= '0;
      end else if (cmd.push) begin
        sp_r <= sp_r + SPW'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_m1;
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.in_accept  = accept;
    sts.in_last    = in_ch.last_card;
    sts.count_zero = (count_r == '0);
    sts.key_gt     = (key_a_r > rd_data_r);
    sts.push_ok    = ((LW'(lo_r) + LW'(1)) < LW'(hi_r)) && (sp_r < SPW'(STACK_DEPTH));
    sts.sp_zero    = (sp_r == '0);
    sts.top_done   = (top_f.phase == PH_DONE);
    sts.emit_last  = (CW'(idx_r) == count_m1);
    sts.out_taken  = out_valid_r & out_ch.ready;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_suit         = out_suit_r;
  assign out_ch.out_value_digits = out_digits_r;
  assign out_ch.end_of_batch     = out_eob_r;
  assign out_ch.overflow         = out_ovf_r;

endmodule

// ===== hdl/card_key_stooge_sorter.sv =====
// Card key batch sorter: loads cards, stooge sorts them, emits them in order.
// Usage: send cards one word at a time on in_ch (suit, value_digits, last_card).
// Each card is taken in one cycle while loading; cards beyond MAX_CARDS are
// dropped and every result of that batch then carries overflow. The word with
// last_card set closes the batch: in_ch.ready falls and the batch is sorted in
// place in the card store by stooge sort on a stack of (lo, hi, phase) frames.
// Each compare-swap of a range's ends passes through the single read port of
// the card store (read lo, read hi, compare, optional write-back, push), and
// each frame step either pops a finished frame or takes its next subrange.
// Results then leave on out_ch in ascending key order (suit first, then the
// digits), each one only after the previous one is taken; end_of_batch marks
// the last one. A stalled receiver holds the output register and the block
// simply waits. in_ch.ready returns after the last result is taken.
// Reset (rst_n low at a clock edge) empties the batch and the range stack and
// returns to loading; the card store itself is not cleared.
module card_key_stooge_sorter #(
  parameter int MAX_CARDS   = 64,
  parameter int MAX_DIGITS  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cks_in_if.sink    in_ch,
  cks_out_if.source out_ch
);
  import cks_pkg::*;

  cmd_t    cmd;
  status_t sts;

  cks_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  cks_datapath #(
    .MAX_CARDS   (MAX_CARDS),
    .MAX_DIGITS  (MAX_DIGITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
